// ===== sv/first_match_packet_rule_filter_macros.svh =====
// Assertion macros for the packet rule filter controller.
// No dependencies; included by fmprf_ctrl, the module that carries assertions.
`ifndef FIRST_MATCH_PACKET_RULE_FILTER_MACROS_SVH
`define FIRST_MATCH_PACKET_RULE_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FMPRF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FMPRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/fmprf_pkg.sv =====
// Package for the packet rule filter: sizes, codes, rule record and
// controller/datapath interface structs. No dependencies.
`default_nettype none

package fmprf_pkg;

    localparam int RULES = 16;
    localparam int IDX_W = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int CNT_W = $clog2(RULES + 1);
    localparam int NUM_W = 5;
    localparam int CMP_W = (CNT_W > NUM_W) ? CNT_W : NUM_W;

    localparam logic [1:0] OP_CLASSIFY = 2'd0;
    localparam logic [1:0] OP_APPEND   = 2'd1;
    localparam logic [1:0] OP_REMOVE   = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_NO_RULE = 2'd2;

    localparam int WILD_SRC_ADDR = 0;
    localparam int WILD_DST_ADDR = 1;
    localparam int WILD_PROTO    = 2;
    localparam int WILD_SPORT    = 3;
    localparam int WILD_DPORT    = 4;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [7:0]  protocol;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [4:0]  wild;
        logic        action;
    } rule_t;

    typedef struct packed {
        logic       capture;
        logic       scan_init;
        logic       scan_dec;
        logic       rm_init;
        logic       rm_inc;
        logic       rd_en;
        logic       rd_next;
        logic       wr_append;
        logic       wr_shift;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       hit_wr;
        logic       status_wr;
        logic [1:0] status_code;
        logic       load_result;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       count_zero;
        logic       table_full;
        logic       num_bad;
        logic       hit;
        logic       idx_zero;
        logic       shift_last;
        logic       out_busy;
    } stat_t;

endpackage

`default_nettype wire

// ===== sv/fmprf_datapath.sv =====
// Datapath of the packet rule filter: item registers, rule memory, rule
// count, scan index, match compare and result register. Uses fmprf_pkg.
`default_nettype none

module fmprf_datapath (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic               cfg_wr_data,
    input  wire logic [1:0]         s_op,
    input  wire logic [31:0]        s_src_addr,
    input  wire logic [31:0]        s_dst_addr,
    input  wire logic [7:0]         s_protocol,
    input  wire logic [15:0]        s_sport,
    input  wire logic [15:0]        s_dport,
    input  wire logic               s_ports_present,
    input  wire logic [4:0]         s_wild_mask,
    input  wire logic               s_rule_accept,
    input  wire logic [4:0]         s_rule_number,
    input  wire fmprf_pkg::cmd_t    cmd,
    output fmprf_pkg::stat_t        stat,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_verdict_accept,
    output logic                    m_matched,
    output logic [4:0]              m_matched_number,
    output logic [1:0]              m_status,
    output logic [4:0]              m_rule_total
);
    import fmprf_pkg::*;

    rule_t            rule_mem [RULES];
    rule_t            rd_data_reg;

    logic [1:0]       op_reg;
    rule_t            item_reg;
    logic             ports_reg;
    logic [NUM_W-1:0] num_reg;

    logic             default_accept_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             hit_reg;
    logic [1:0]       status_reg;

    logic             m_valid_reg;
    logic             verdict_reg;
    logic             matched_reg;
    logic [4:0]       mnum_reg;
    logic [1:0]       mstatus_reg;
    logic [4:0]       total_reg;

    logic [IDX_W:0]   idx_p1;
    logic [IDX_W:0]   count_wide;
    logic [CMP_W-1:0] num_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] num_m1;
    logic [CNT_W-1:0] count_m1;
    logic             rule_hit;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    rule_t            wr_data;
    logic             wr_en;
    logic             verdict_calc;

    assign idx_p1     = {1'b0, idx_reg} + (IDX_W + 1)'(1);
    assign count_wide = (IDX_W + 1)'(count_reg);
    assign num_ext    = CMP_W'(num_reg);
    assign cnt_ext    = CMP_W'(count_reg);
    assign num_m1     = num_ext - CMP_W'(1);
    assign count_m1   = count_reg - CNT_W'(1);

    // Compare the fetched rule against the held packet header.
    always_comb begin
        rule_hit = (rd_data_reg.action != default_accept_reg);
        if (!rd_data_reg.wild[WILD_SRC_ADDR] && rd_data_reg.src_addr != item_reg.src_addr) begin
            rule_hit = 1'b0;
        end
        if (!rd_data_reg.wild[WILD_DST_ADDR] && rd_data_reg.dst_addr != item_reg.dst_addr) begin
            rule_hit = 1'b0;
        end
        if (!rd_data_reg.wild[WILD_PROTO] && rd_data_reg.protocol != item_reg.protocol) begin
            rule_hit = 1'b0;
        end
        if (!rd_data_reg.wild[WILD_SPORT]
            && (!ports_reg || rd_data_reg.sport != item_reg.sport)) begin
            rule_hit = 1'b0;
        end
        if (!rd_data_reg.wild[WILD_DPORT]
            && (!ports_reg || rd_data_reg.dport != item_reg.dport)) begin
            rule_hit = 1'b0;
        end
    end

    assign stat.op         = op_reg;
    assign stat.count_zero = (count_reg == '0);
    assign stat.table_full = (count_reg == CNT_W'(RULES));
    assign stat.num_bad    = (num_ext == '0) || (num_ext > cnt_ext);
    assign stat.hit        = rule_hit;
    assign stat.idx_zero   = (idx_reg == '0);
    assign stat.shift_last = (idx_p1 >= count_wide);
    assign stat.out_busy   = m_valid_reg && !m_ready;

    // Rule memory: one write port, one registered read port.
    assign rd_addr = cmd.rd_next ? idx_p1[IDX_W-1:0] : idx_reg;
    assign wr_en   = cmd.wr_append || cmd.wr_shift;
    assign wr_addr = cmd.wr_append ? count_reg[IDX_W-1:0] : idx_reg;
    assign wr_data = cmd.wr_append ? item_reg : rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rule_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= rule_mem[rd_addr];
        end
    end

    // Item registers.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg            <= s_op;
            item_reg.src_addr <= s_src_addr;
            item_reg.dst_addr <= s_dst_addr;
            item_reg.protocol <= s_protocol;
            item_reg.sport    <= s_sport;
            item_reg.dport    <= s_dport;
            item_reg.wild     <= s_wild_mask;
            item_reg.action   <= s_rule_accept;
            ports_reg         <= s_ports_present;
            num_reg           <= s_rule_number;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.cnt_inc) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.cnt_dec) begin
            count_next = count_m1;
        end
    end

    always_comb begin
        idx_next = idx_reg;
        priority if (cmd.scan_init) begin
            idx_next = count_m1[IDX_W-1:0];
        end else if (cmd.rm_init) begin
            idx_next = num_m1[IDX_W-1:0];
        end else if (cmd.scan_dec) begin
            idx_next = idx_reg - IDX_W'(1);
        end else if (cmd.rm_inc) begin
            idx_next = idx_p1[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg          <= '0;
            default_accept_reg <= 1'b0;
            hit_reg            <= 1'b0;
            status_reg         <= STATUS_OK;
            m_valid_reg        <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cfg_wr_en) begin
                default_accept_reg <= cfg_wr_data;
            end
            if (cmd.capture) begin
                hit_reg    <= 1'b0;
                status_reg <= STATUS_OK;
            end else begin
                if (cmd.hit_wr) begin
                    hit_reg <= 1'b1;
                end
                if (cmd.status_wr) begin
                    status_reg <= cmd.status_code;
                end
            end
            if (cmd.load_result) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
    end

    always_comb begin
        if (hit_reg) begin
            verdict_calc = rd_data_reg.action;
        end else if (op_reg == OP_CLASSIFY) begin
            verdict_calc = default_accept_reg;
        end else begin
            verdict_calc = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            verdict_reg <= verdict_calc;
            matched_reg <= hit_reg;
            mnum_reg    <= hit_reg ? 5'(idx_p1) : 5'd0;
            mstatus_reg <= status_reg;
            total_reg   <= 5'(count_reg);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_verdict_accept = verdict_reg;
    assign m_matched        = matched_reg;
    assign m_matched_number = mnum_reg;
    assign m_status         = mstatus_reg;
    assign m_rule_total     = total_reg;

endmodule

`default_nettype wire

// ===== sv/fmprf_ctrl.sv =====
// Controller of the packet rule filter: sequences classify scans, appends
// and removes through the datapath. Uses fmprf_pkg and the macros header.
`default_nettype none

`include "first_match_packet_rule_filter_macros.svh"

module fmprf_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire fmprf_pkg::stat_t stat,
    output fmprf_pkg::cmd_t       cmd
);
    import fmprf_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_CL_RD  = 3'd2;
    localparam logic [2:0] ST_CL_CMP = 3'd3;
    localparam logic [2:0] ST_RM_RD  = 3'd4;
    localparam logic [2:0] ST_RM_WR  = 3'd5;
    localparam logic [2:0] ST_FIN    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_FIN;
                unique case (stat.op)
                    OP_CLASSIFY: begin
                        if (!stat.count_zero) begin
                            cmd.scan_init = 1'b1;
                            state_next    = ST_CL_RD;
                        end
                    end
                    OP_APPEND: begin
                        if (stat.table_full) begin
                            cmd.status_wr   = 1'b1;
                            cmd.status_code = STATUS_FULL;
                        end else begin
                            cmd.wr_append = 1'b1;
                            cmd.cnt_inc   = 1'b1;
                        end
                    end
                    OP_REMOVE: begin
                        if (stat.num_bad) begin
                            cmd.status_wr   = 1'b1;
                            cmd.status_code = STATUS_NO_RULE;
                        end else begin
                            cmd.rm_init = 1'b1;
                            state_next  = ST_RM_RD;
                        end
                    end
                    default: begin
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_CL_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_CL_CMP;
            end
            ST_CL_CMP: begin
                priority if (stat.hit) begin
                    cmd.hit_wr = 1'b1;
                    state_next = ST_FIN;
                end else if (stat.idx_zero) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.scan_dec = 1'b1;
                    state_next   = ST_CL_RD;
                end
            end
            ST_RM_RD: begin
                if (stat.shift_last) begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = ST_FIN;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_next = 1'b1;
                    state_next  = ST_RM_WR;
                end
            end
            ST_RM_WR: begin
                cmd.wr_shift = 1'b1;
                cmd.rm_inc   = 1'b1;
                state_next   = ST_RM_RD;
            end
            ST_FIN: begin
                if (!stat.out_busy) begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `FMPRF_ASSERT_NOW(a_one_writer, aclk, aresetn, cmd.wr_append, !cmd.wr_shift, "append and shift write together")
    `FMPRF_ASSERT_NOW(a_load_free, aclk, aresetn, cmd.load_result, !stat.out_busy, "result loaded over a pending transaction")
    `FMPRF_ASSERT_NEXT(a_hit_finishes, aclk, aresetn, cmd.hit_wr, state_reg == ST_FIN, "hit did not finish the scan")
    `FMPRF_ASSERT_NEXT(a_accept_exec, aclk, aresetn, s_valid && s_ready, state_reg == ST_EXEC, "accepted transaction not dispatched")

endmodule

`default_nettype wire

// ===== sv/first_match_packet_rule_filter.sv =====
// One transaction in flight; the next is taken from the cycle after the last is loaded
// into the result register, and loading waits while a previous result is still pending.
// Reset (aresetn low, synchronous) empties the table, clears default_accept, drops any
// pending result; rule memory contents are left as they are and need no clearing.
`default_nettype none

module first_match_packet_rule_filter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // default policy register
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    // input transactions
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_op,
    input  wire logic [31:0] s_src_addr,
    input  wire logic [31:0] s_dst_addr,
    input  wire logic [7:0]  s_protocol,
    input  wire logic [15:0] s_sport,
    input  wire logic [15:0] s_dport,
    input  wire logic        s_ports_present,
    input  wire logic [4:0]  s_wild_mask,
    input  wire logic        s_rule_accept,
    input  wire logic [4:0]  s_rule_number,
    // result transactions
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_verdict_accept,
    output logic             m_matched,
    output logic [4:0]       m_matched_number,
    output logic [1:0]       m_status,
    output logic [4:0]       m_rule_total
);
    import fmprf_pkg::*;

    // Command and status between the sequencer and the datapath.
    cmd_t  cmd;
    stat_t stat;

    // The controller walks the rules newest first on a classify, writes the
    // next slot on an append, and on a remove moves each higher rule down one
    // slot, reading and writing the rule memory on alternate cycles.
    fmprf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // The datapath holds the transaction, the rule memory, the rule count,
    // the match compare and the output register that parts the two sides.
    fmprf_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_op             (s_op),
        .s_src_addr       (s_src_addr),
        .s_dst_addr       (s_dst_addr),
        .s_protocol       (s_protocol),
        .s_sport          (s_sport),
        .s_dport          (s_dport),
        .s_ports_present  (s_ports_present),
        .s_wild_mask      (s_wild_mask),
        .s_rule_accept    (s_rule_accept),
        .s_rule_number    (s_rule_number),
        .cmd              (cmd),
        .stat             (stat),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_verdict_accept (m_verdict_accept),
        .m_matched        (m_matched),
        .m_matched_number (m_matched_number),
        .m_status         (m_status),
        .m_rule_total     (m_rule_total)
    );

endmodule

`default_nettype wire

// ===== dv/first_match_rule_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the packet rule filter: keeps its own rule table and default
// policy, predicts every result and compares it field by field. Uses fmprf_pkg.
module first_match_rule_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [1:0]  s_op,
    input  wire logic [31:0] s_src_addr,
    input  wire logic [31:0] s_dst_addr,
    input  wire logic [7:0]  s_protocol,
    input  wire logic [15:0] s_sport,
    input  wire logic [15:0] s_dport,
    input  wire logic        s_ports_present,
    input  wire logic [4:0]  s_wild_mask,
    input  wire logic        s_rule_accept,
    input  wire logic [4:0]  s_rule_number,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic        m_verdict_accept,
    input  wire logic        m_matched,
    input  wire logic [4:0]  m_matched_number,
    input  wire logic [1:0]  m_status,
    input  wire logic [4:0]  m_rule_total,
    output int               fail_count,
    output int               outstanding
);
    import fmprf_pkg::*;

    typedef struct packed {
        logic       verdict_accept;
        logic       matched;
        logic [4:0] matched_number;
        logic [1:0] status;
        logic [4:0] rule_total;
    } filter_result_t;

    rule_t          rule_table [RULES];
    int unsigned    rule_cnt;
    logic           policy_accept;
    filter_result_t results_due [$];
    int             mismatches = 0;

    initial outstanding = 0;
    assign fail_count = mismatches;

    function automatic void compare_field(string field, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
        end
    endfunction

    always @(posedge aclk) begin : track_filter
        filter_result_t got;
        filter_result_t want;
        rule_t          cand;
        int unsigned    k;
        logic           hit;
        if (!aresetn) begin
            rule_cnt = 0;
            policy_accept = 1'b0;
            results_due.delete();
        end else begin
            if (cfg_wr_en)
                policy_accept = cfg_wr_data;

            if (m_valid && m_ready) begin
                got = '{verdict_accept: m_verdict_accept, matched: m_matched,
                        matched_number: m_matched_number, status: m_status,
                        rule_total: m_rule_total};
                if (results_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with none expected, expected nothing, actual %p",
                             $time, got);
                end else begin
                    want = results_due.pop_front();
                    compare_field("verdict_accept", want.verdict_accept, got.verdict_accept);
                    compare_field("matched", want.matched, got.matched);
                    compare_field("matched_number", want.matched_number, got.matched_number);
                    compare_field("status", want.status, got.status);
                    compare_field("rule_total", want.rule_total, got.rule_total);
                end
            end

            if (s_valid && s_ready) begin
                want = '0;
                want.status = STATUS_OK;
                case (s_op)
                    OP_CLASSIFY: begin
                        want.verdict_accept = policy_accept;
                        // newest first; rules that agree with the policy can't change it
                        for (k = rule_cnt; k > 0 && !want.matched; k--) begin
                            cand = rule_table[k - 1];
                            hit = (cand.action != policy_accept)
                                && (cand.wild[WILD_SRC_ADDR] || cand.src_addr == s_src_addr)
                                && (cand.wild[WILD_DST_ADDR] || cand.dst_addr == s_dst_addr)
                                && (cand.wild[WILD_PROTO] || cand.protocol == s_protocol)
                                && (cand.wild[WILD_SPORT]
                                    || (s_ports_present && cand.sport == s_sport))
                                && (cand.wild[WILD_DPORT]
                                    || (s_ports_present && cand.dport == s_dport));
                            if (hit) begin
                                want.verdict_accept = cand.action;
                                want.matched = 1'b1;
                                want.matched_number = k[4:0];
                            end
                        end
                    end
                    OP_APPEND: begin
                        if (rule_cnt >= RULES) begin
                            want.status = STATUS_FULL;
                        end else begin
                            rule_table[rule_cnt] = '{src_addr: s_src_addr, dst_addr: s_dst_addr,
                                                     protocol: s_protocol, sport: s_sport,
                                                     dport: s_dport, wild: s_wild_mask,
                                                     action: s_rule_accept};
                            rule_cnt++;
                        end
                    end
                    OP_REMOVE: begin
                        if (s_rule_number == 0 || s_rule_number > rule_cnt) begin
                            want.status = STATUS_NO_RULE;
                        end else begin
                            for (k = s_rule_number - 1; k + 1 < rule_cnt; k++)
                                rule_table[k] = rule_table[k + 1];
                            rule_cnt--;
                        end
                    end
                    default: ;
                endcase
                want.rule_total = rule_cnt[4:0];
                results_due.push_back(want);
            end
        end
        outstanding <= results_due.size();
    end

endmodule

// ===== dv/tb_first_match_packet_rule_filter.sv =====
`timescale 1ns / 1ps
// Top of the packet rule filter testbench: drives rule edits, packet headers
// and policy writes, and prints the verdict. Needs fmprf_pkg, the filter and
// first_match_rule_checker.
module tb_first_match_packet_rule_filter;
    import fmprf_pkg::*;

    // the block ignores this op code apart from reporting the rule total
    localparam logic [1:0] OP_UNDEFINED   = 2'd3;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         PHASES         = 8;
    localparam int         PHASE_ITEMS    = 200;
    localparam int         CALM_PHASE     = 3;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [7:0]  protocol;
        logic [15:0] sport;
        logic [15:0] dport;
        logic        ports_present;
        logic [4:0]  wild_mask;
        logic        rule_accept;
        logic [4:0]  rule_number;
    } filter_req_t;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        cfg_wr_en       = 1'b0;
    logic        cfg_wr_data     = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [1:0]  s_op            = '0;
    logic [31:0] s_src_addr      = '0;
    logic [31:0] s_dst_addr      = '0;
    logic [7:0]  s_protocol      = '0;
    logic [15:0] s_sport         = '0;
    logic [15:0] s_dport         = '0;
    logic        s_ports_present = 1'b0;
    logic [4:0]  s_wild_mask     = '0;
    logic        s_rule_accept   = 1'b0;
    logic [4:0]  s_rule_number   = '0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic        m_verdict_accept;
    logic        m_matched;
    logic [4:0]  m_matched_number;
    logic [1:0]  m_status;
    logic [4:0]  m_rule_total;

    int          fail_count;
    int          outstanding;
    int          idle_cycles     = 0;
    // no idling on either side while calm is set
    logic        calm            = 1'b0;

    // rule fields as stored, used only to steer stimulus toward real hits
    filter_req_t table_shadow [$];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    first_match_packet_rule_filter u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_src_addr       (s_src_addr),
        .s_dst_addr       (s_dst_addr),
        .s_protocol       (s_protocol),
        .s_sport          (s_sport),
        .s_dport          (s_dport),
        .s_ports_present  (s_ports_present),
        .s_wild_mask      (s_wild_mask),
        .s_rule_accept    (s_rule_accept),
        .s_rule_number    (s_rule_number),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_verdict_accept (m_verdict_accept),
        .m_matched        (m_matched),
        .m_matched_number (m_matched_number),
        .m_status         (m_status),
        .m_rule_total     (m_rule_total)
    );

    first_match_rule_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_src_addr       (s_src_addr),
        .s_dst_addr       (s_dst_addr),
        .s_protocol       (s_protocol),
        .s_sport          (s_sport),
        .s_dport          (s_dport),
        .s_ports_present  (s_ports_present),
        .s_wild_mask      (s_wild_mask),
        .s_rule_accept    (s_rule_accept),
        .s_rule_number    (s_rule_number),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_verdict_accept (m_verdict_accept),
        .m_matched        (m_matched),
        .m_matched_number (m_matched_number),
        .m_status         (m_status),
        .m_rule_total     (m_rule_total),
        .fail_count       (fail_count),
        .outstanding      (outstanding)
    );

    // Result side: hold m_ready low about a fifth of the time unless calm.
    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 21);
    end

    // Watchdog: count cycles in which neither channel moves a transaction.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d results outstanding", $time, outstanding);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic filter_req_t make_req(logic [1:0] op, logic [31:0] sa, logic [31:0] da,
                                             logic [7:0] pr, logic [15:0] sp, logic [15:0] dp,
                                             logic ports, logic [4:0] wild, logic act,
                                             logic [4:0] num);
        filter_req_t r;
        r = '{op: op, src_addr: sa, dst_addr: da, protocol: pr, sport: sp, dport: dp,
              ports_present: ports, wild_mask: wild, rule_accept: act, rule_number: num};
        return r;
    endfunction

    // Follow appends and removes so the stimulus knows what the table holds.
    function automatic void track_table(filter_req_t r);
        if (r.op == OP_APPEND && table_shadow.size() < RULES)
            table_shadow.push_back(r);
        else if (r.op == OP_REMOVE && r.rule_number >= 1 && r.rule_number <= table_shadow.size())
            table_shadow.delete(r.rule_number - 1);
    endfunction

    // Random transaction shaped by the table contents: packets mostly copy a
    // stored rule with a few fields disturbed, removes mostly name real rules.
    function automatic filter_req_t random_req();
        filter_req_t r;
        filter_req_t base;
        int          size;
        int          app_w;
        int          rem_w;
        int          pick;
        r = make_req(2'($urandom_range(3)), $urandom(), $urandom(), 8'($urandom()),
                     16'($urandom()), 16'($urandom()), 1'($urandom()),
                     5'($urandom_range(31)), 1'($urandom()), 5'($urandom_range(31)));
        size  = table_shadow.size();
        app_w = (size < 4) ? 45 : (size >= RULES) ? 8 : 18;
        rem_w = (size == 0) ? 4 : 18;
        pick  = $urandom_range(99);
        if (pick < app_w)
            r.op = OP_APPEND;
        else if (pick < app_w + rem_w)
            r.op = OP_REMOVE;
        else if (pick < app_w + rem_w + 3)
            r.op = OP_UNDEFINED;
        else
            r.op = OP_CLASSIFY;

        if (r.op == OP_REMOVE && size > 0 && $urandom_range(99) < 80)
            r.rule_number = 5'($urandom_range(1, size));

        if (r.op == OP_CLASSIFY && size > 0 && $urandom_range(99) < 70) begin
            base = table_shadow[$urandom_range(size - 1)];
            if ($urandom_range(3) != 0) r.src_addr = base.src_addr;
            if ($urandom_range(3) != 0) r.dst_addr = base.dst_addr;
            if ($urandom_range(3) != 0) r.protocol = base.protocol;
            if ($urandom_range(3) != 0) r.sport = base.sport;
            if ($urandom_range(3) != 0) r.dport = base.dport;
            r.ports_present = ($urandom_range(99) < 85);
        end
        return r;
    endfunction

    // Present one transaction and hold it until accepted. Valid stays high on
    // return so back-to-back transactions never drop it within a time step.
    task automatic send_request(filter_req_t r);
        int gap;
        if (!calm && $urandom_range(99) < 21) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_op            <= r.op;
        s_src_addr      <= r.src_addr;
        s_dst_addr      <= r.dst_addr;
        s_protocol      <= r.protocol;
        s_sport         <= r.sport;
        s_dport         <= r.dport;
        s_ports_present <= r.ports_present;
        s_wild_mask     <= r.wild_mask;
        s_rule_accept   <= r.rule_accept;
        s_rule_number   <= r.rule_number;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        track_table(r);
    endtask

    // Drop valid and hold off until every expected result has been taken.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // Write the default policy with the block idle.
    task automatic set_policy(logic accept);
        settle();
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= accept;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin : stimulus
        int p;
        int n;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: default policy is drop from reset.
        // classify on an empty table, all-zero and all-ones headers
        send_request(make_req(OP_CLASSIFY, '0, '0, '0, '0, '0, 1'b0, '0, 1'b0, '0));
        send_request(make_req(OP_CLASSIFY, '1, '1, '1, '1, '1, 1'b1, '1, 1'b1, '1));
        // remove from an empty table, including number zero
        send_request(make_req(OP_REMOVE, '0, '0, '0, '0, '0, 1'b0, '0, 1'b0, 5'd0));
        // exact accept rule at the field maxima; hit with ports, miss without
        send_request(make_req(OP_APPEND, '1, '1, '1, '1, '1, 1'b0, 5'h00, 1'b1, '0));
        send_request(make_req(OP_CLASSIFY, '1, '1, '1, '1, '1, 1'b1, '0, 1'b0, '0));
        send_request(make_req(OP_CLASSIFY, '1, '1, '1, '1, '1, 1'b0, '0, 1'b0, '0));
        // both ports wildcarded: a header without ports may still match
        send_request(make_req(OP_APPEND, 32'h0A00_0001, '0, 8'd6, 16'd1, 16'd2, 1'b0,
                              (5'b1 << WILD_SPORT) | (5'b1 << WILD_DPORT), 1'b1, '0));
        send_request(make_req(OP_CLASSIFY, 32'h0A00_0001, '0, 8'd6, 16'd7, 16'd9, 1'b0,
                              '0, 1'b0, '0));
        // drop rule that matches anything: skipped while the policy is drop
        send_request(make_req(OP_APPEND, '0, '0, '0, '0, '0, 1'b0, 5'h1F, 1'b0, '0));
        // protocol wildcard
        send_request(make_req(OP_APPEND, 32'd1, 32'd2, 8'd6, 16'd80, 16'd443, 1'b0,
                              5'b1 << WILD_PROTO, 1'b1, '0));
        send_request(make_req(OP_CLASSIFY, 32'd1, 32'd2, 8'd17, 16'd80, 16'd443, 1'b1,
                              '0, 1'b0, '0));
        // undefined op with every field at its maximum
        send_request(make_req(OP_UNDEFINED, '1, '1, '1, '1, '1, 1'b1, '1, 1'b1, '1));
        // absent number, then delete rule 2 so the later rules shift down
        send_request(make_req(OP_REMOVE, '0, '0, '0, '0, '0, 1'b0, '0, 1'b0, 5'd31));
        send_request(make_req(OP_REMOVE, '0, '0, '0, '0, '0, 1'b0, '0, 1'b0, 5'd2));
        send_request(make_req(OP_CLASSIFY, 32'd1, 32'd2, 8'd17, 16'd80, 16'd443, 1'b1,
                              '0, 1'b0, '0));
        // fill the table, then append once more into a full one
        while (table_shadow.size() < RULES)
            send_request(make_req(OP_APPEND, $urandom(), $urandom(), 8'($urandom()),
                                  16'($urandom()), 16'($urandom()), 1'b0,
                                  5'($urandom_range(31)), 1'($urandom()), '0));
        send_request(make_req(OP_APPEND, '0, '0, '0, '0, '0, 1'b0, 5'h1F, 1'b1, '0));
        // oldest and newest removals on a full table
        send_request(make_req(OP_REMOVE, '0, '0, '0, '0, '0, 1'b0, '0, 1'b0, 5'd1));
        send_request(make_req(OP_REMOVE, '0, '0, '0, '0, '0, 1'b0, '0, 1'b0, 5'(RULES - 1)));

        // Random phases, alternating the default policy; each policy write
        // first waits for the pipeline to drain. One phase runs with no idling.
        for (p = 0; p < PHASES; p++) begin
            set_policy(p % 2 == 0);
            calm <= (p == CALM_PHASE);
            for (n = 0; n < PHASE_ITEMS; n++)
                send_request(random_req());
        end

        settle();
        repeat (40) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
